/* design/grid_nms_pkg.sv */
// shared field widths, candidate record type and register indexes for keypoint nms
package grid_nms_pkg;

    localparam int CoordW = 10;
    localparam int ConfW  = 16;
    localparam int SizeW  = 11;
    localparam int RadW   = 4;
    localparam int BordW  = 9;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RADIUS = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_BORDER = 2'd3;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [ConfW-1:0]  conf;
    } t_cand;

endpackage

/* design/grid_keypoint_nms_core.sv */
// keypoint non-maximum suppression core with a shared compare unit over the candidate list
//
// input channel: one candidate request (x, y, confidence, last flag) per cycle while
// o_in_stall is low; candidates outside the image are ignored, those beyond MAX_POINTS
// are dropped and flagged as overflow. the request with last_point set starts the frame
// processing and o_in_stall stays high until the last result has been taken.
// processing walks the candidate list with one comparator, one pair at a time:
// a duplicate pass and a suppression pass each sweep all stored candidates for every
// remaining candidate i, then every emitted point costs a raster search over the list.
// results come out in raster order, the last one flagged; an empty frame gives one
// result with point valid low. the output register holds its request while
// i_out_stall is high and processing waits. configuration writes are always taken
// (o_cfg_ready high) and are meant to change only between frames.
// reset clears the candidate count and flags and sets the configuration to its defaults;
// no clearing pass is needed since only listed candidates are ever looked at.
module grid_keypoint_nms_core
    import grid_nms_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CoordW-1:0]  i_point_x,
    input  logic [CoordW-1:0]  i_point_y,
    input  logic [ConfW-1:0]   i_confidence,
    input  logic               i_last_point,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CoordW-1:0]  o_out_x,
    output logic [CoordW-1:0]  o_out_y,
    output logic [ConfW-1:0]   o_out_confidence,
    output logic               o_point_valid,
    output logic               o_last_result,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [SizeW-1:0]   i_cfg_data
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [12:0] LimW = 13'(MAX_WIDTH);
    localparam logic [12:0] LimH = 13'(MAX_HEIGHT);
    localparam logic [4:0]  LimR = 5'(MAX_RADIUS);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_IRD  = 3'd1;
    localparam logic [2:0] S_ILAT = 3'd2;
    localparam logic [2:0] S_JRD  = 3'd3;
    localparam logic [2:0] S_JEV  = 3'd4;
    localparam logic [2:0] S_IEND = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [1:0] P_DEDUP = 2'd0;
    localparam logic [1:0] P_SUPP  = 2'd1;
    localparam logic [1:0] P_EMIT  = 2'd2;

    // configuration
    logic [SizeW-1:0] r_width, r_height;
    logic [RadW-1:0]  r_radius;
    logic [BordW-1:0] r_border;

    // control
    logic [2:0]  r_state;
    logic [1:0]  r_pass;
    logic [CW-1:0] r_count, r_i, r_j, r_cnt;
    logic        r_ovf;
    logic [MAX_POINTS-1:0] r_dup, r_live, r_kept, r_done;
    logic        r_oany;

    // latched candidate i and best found
    logic [CoordW-1:0] r_ix, r_iy;
    logic [ConfW-1:0]  r_ic;
    t_cand             r_best;
    logic [IW-1:0]     r_bidx;

    // candidate memory
    t_cand mem [MAX_POINTS];
    t_cand r_rd;
    logic          w_we;
    logic [IW-1:0] w_wa, w_ra;
    t_cand         w_wd;

    // effective geometry
    logic [12:0] w_w, w_h;
    logic [4:0]  w_r;
    logic        w_in_acc, w_inside;

    assign w_w = ({2'b0, r_width} > LimW) ? LimW : {2'b0, r_width};
    assign w_h = ({2'b0, r_height} > LimH) ? LimH : {2'b0, r_height};
    assign w_r = ({1'b0, r_radius} > LimR) ? LimR : {1'b0, r_radius};

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == S_OUT);
    assign w_in_acc = i_in_valid && (r_state == S_LOAD);
    assign w_inside = ({3'b0, i_point_x} < w_w) && ({3'b0, i_point_y} < w_h);

    // memory port selection
    always_comb begin
        w_we = 1'b0;
        w_wa = r_count[IW-1:0];
        w_wd = '{x: i_point_x, y: i_point_y, conf: i_confidence};
        if (r_state == S_LOAD) begin
            w_we = w_in_acc && w_inside && (r_count < MaxCnt);
        end else if (r_state == S_IEND && r_pass == P_DEDUP) begin
            w_we = 1'b1;
            w_wa = r_i[IW-1:0];
            w_wd = '{x: r_ix, y: r_iy, conf: r_ic};
        end
        w_ra = (r_state == S_IRD) ? r_i[IW-1:0] : r_j[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd <= mem[w_ra];
    end

    // shared compare unit between candidate i and the one just read
    logic [10:0] w_dx, w_dy, w_adx, w_ady;
    logic        w_near, w_same, w_jin, w_margin, w_elig, w_better;

    assign w_dx  = {1'b0, r_rd.x} - {1'b0, r_ix};
    assign w_dy  = {1'b0, r_rd.y} - {1'b0, r_iy};
    assign w_adx = w_dx[10] ? (11'd0 - w_dx) : w_dx;
    assign w_ady = w_dy[10] ? (11'd0 - w_dy) : w_dy;
    assign w_near = (w_adx <= {6'b0, w_r}) && (w_ady <= {6'b0, w_r});
    assign w_same = (r_rd.x == r_ix) && (r_rd.y == r_iy);
    assign w_jin  = ({3'b0, r_rd.x} < w_w) && ({3'b0, r_rd.y} < w_h);
    assign w_margin = ({3'b0, r_rd.x} >= {4'b0, r_border})
                   && (({3'b0, r_rd.x} + {4'b0, r_border}) < w_w)
                   && ({3'b0, r_rd.y} >= {4'b0, r_border})
                   && (({3'b0, r_rd.y} + {4'b0, r_border}) < w_h);
    assign w_elig = r_kept[r_j[IW-1:0]] && !r_done[r_j[IW-1:0]] && w_margin;
    assign w_better = (r_cnt == '0) || ({r_rd.y, r_rd.x} < {r_best.y, r_best.x});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
            r_radius <= 4'd4;
            r_border <= 9'd4;
            r_state  <= S_LOAD;
            r_pass   <= P_DEDUP;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_dup    <= '0;
            r_live   <= '0;
            r_kept   <= '0;
            r_done   <= '0;
            r_oany   <= 1'b0;
            o_last_result <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_RADIUS: r_radius <= i_cfg_data[RadW-1:0];
                    CFG_BORDER: r_border <= i_cfg_data[BordW-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                // candidate load
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_inside) begin
                            if (r_count < MaxCnt) r_count <= r_count + 1'b1;
                            else r_ovf <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_pass  <= P_DEDUP;
                            r_i     <= '0;
                            r_state <= S_IRD;
                        end
                    end
                end
                // pick next candidate i, move to the next pass or start a raster search
                S_IRD: begin
                    if (r_pass == P_EMIT) begin
                        r_j     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_JRD;
                    end else if (r_i == r_count) begin
                        r_i <= '0;
                        if (r_pass == P_DEDUP) begin
                            r_pass <= P_SUPP;
                            r_live <= ~r_dup;
                        end else begin
                            r_pass <= P_EMIT;
                        end
                    end else if ((r_pass == P_DEDUP && r_dup[r_i[IW-1:0]])
                              || (r_pass == P_SUPP && !r_live[r_i[IW-1:0]])) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_ILAT;
                    end
                end
                S_ILAT: begin
                    r_ix    <= r_rd.x;
                    r_iy    <= r_rd.y;
                    r_ic    <= r_rd.conf;
                    r_j     <= '0;
                    r_state <= S_JRD;
                end
                // sweep over j
                S_JRD: begin
                    r_state <= (r_j == r_count) ? S_IEND : S_JEV;
                end
                S_JEV: begin
                    case (r_pass)
                        P_DEDUP: begin
                            if (r_j > r_i && w_same) begin
                                r_ic <= r_rd.conf;
                                r_dup[r_j[IW-1:0]] <= 1'b1;
                            end
                        end
                        P_SUPP: begin
                            if (r_j != r_i && !r_dup[r_j[IW-1:0]] && w_near && w_jin
                                && r_rd.conf < r_ic) begin
                                r_live[r_j[IW-1:0]] <= 1'b0;
                                r_kept[r_j[IW-1:0]] <= 1'b0;
                            end
                        end
                        default: begin
                            if (w_elig) begin
                                r_cnt <= r_cnt + 1'b1;
                                if (w_better) begin
                                    r_best <= r_rd;
                                    r_bidx <= r_j[IW-1:0];
                                end
                            end
                        end
                    endcase
                    r_j     <= r_j + 1'b1;
                    r_state <= S_JRD;
                end
                // finish candidate i or one raster search
                S_IEND: begin
                    case (r_pass)
                        P_DEDUP: begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_IRD;
                        end
                        P_SUPP: begin
                            r_kept[r_i[IW-1:0]] <= 1'b1;
                            r_live[r_i[IW-1:0]] <= 1'b0;
                            r_i     <= r_i + 1'b1;
                            r_state <= S_IRD;
                        end
                        default: begin
                            o_overflow <= r_ovf;
                            if (r_cnt == '0) begin
                                o_out_x          <= '0;
                                o_out_y          <= '0;
                                o_out_confidence <= '0;
                                o_point_valid    <= 1'b0;
                                o_last_result    <= 1'b1;
                            end else begin
                                o_out_x          <= r_best.x;
                                o_out_y          <= r_best.y;
                                o_out_confidence <= r_best.conf;
                                o_point_valid    <= 1'b1;
                                o_last_result    <= (r_cnt == CW'(1));
                                r_done[r_bidx]   <= 1'b1;
                            end
                            r_oany  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                // hold result until taken
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (o_last_result || r_oany && r_cnt == '0) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_dup   <= '0;
                            r_live  <= '0;
                            r_kept  <= '0;
                            r_done  <= '0;
                            r_oany  <= 1'b0;
                            r_pass  <= P_DEDUP;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_IRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule
